// ===== rtl/tccf_pkg.sv =====
// Package for the TCP client connection block: shared types and constants.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package tccf_pkg;

  // Command codes of an input item
  localparam logic CMD_OPEN    = 1'b0;
  localparam logic CMD_SEGMENT = 1'b1;

  // TCP flag bits
  localparam logic [7:0] FL_NONE = 8'h00;
  localparam logic [7:0] FL_FIN  = 8'h01;
  localparam logic [7:0] FL_SYN  = 8'h02;
  localparam logic [7:0] FL_RST  = 8'h04;
  localparam logic [7:0] FL_ACK  = 8'h10;

  // Header constants
  localparam logic [10:0] HDR_LEN     = 11'd20;
  localparam logic [31:0] HDR_BYTES   = 32'd20;
  localparam logic [15:0] PSEUDO_WORD = 16'd26;     // protocol 6 plus length 20
  localparam logic [15:0] OFFSET_WORD = 16'h5000;   // data offset five words

  // Reset values
  localparam logic [15:0] RST_OPEN_SRC_PORT = 16'd1234;
  localparam logic [15:0] RST_OPEN_DST_PORT = 16'd4444;
  localparam logic [31:0] RST_INIT_SEQ      = 32'd1001;
  localparam logic [7:0]  RST_TIMEOUT       = 8'd30;
  localparam logic [15:0] RST_WINDOW        = 16'd1000;
  localparam logic [15:0] RST_DATA_TOTAL    = 16'd257;
  localparam logic [31:0] RST_SRC_ADDR      = 32'hC0A801E9;
  localparam logic [31:0] RST_DST_ADDR      = 32'hC0A80101;

  // Register indexes on the configuration port
  localparam int          PADDR_W = 5;
  localparam logic [2:0]  REG_OPEN_SRC_PORT = 3'd0;
  localparam logic [2:0]  REG_OPEN_DST_PORT = 3'd1;
  localparam logic [2:0]  REG_INIT_SEQ      = 3'd2;
  localparam logic [2:0]  REG_TIMEOUT       = 3'd3;
  localparam logic [2:0]  REG_WINDOW        = 3'd4;
  localparam logic [2:0]  REG_DATA_TOTAL    = 3'd5;

  // Configuration set
  typedef struct packed {
    logic [15:0] open_src_port;
    logic [15:0] open_dst_port;
    logic [31:0] initial_sequence;
    logic [7:0]  timeout_limit;
    logic [15:0] advertised_window;
    logic [15:0] data_total;
  } cfg_t;

  // Header to send, as queued between front and back
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] window;
  } hdr_t;

endpackage

`default_nettype wire

// ===== rtl/tccf_in_if.sv =====
// Input channel of the TCP client connection block: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface tccf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  seg_flags;
  logic [15:0] seg_src_port;
  logic [15:0] seg_dst_port;
  logic [31:0] seg_src_addr;
  logic [31:0] seg_dst_addr;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [10:0] seg_length;

  modport source (
    output valid, command, seg_flags, seg_src_port, seg_dst_port,
           seg_src_addr, seg_dst_addr, seg_seq, seg_ack, seg_length,
    input  ready
  );
  modport sink (
    input  valid, command, seg_flags, seg_src_port, seg_dst_port,
           seg_src_addr, seg_dst_addr, seg_seq, seg_ack, seg_length,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tccf_out_if.sv =====
// Output channel of the TCP client connection block: valid/ready plus one header.
// Depends on nothing.
`default_nettype none

interface tccf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_flags;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [15:0] out_checksum;

  modport source (
    output valid, out_flags, out_src_port, out_dst_port, out_seq, out_ack,
           out_checksum,
    input  ready
  );
  modport sink (
    input  valid, out_flags, out_src_port, out_dst_port, out_seq, out_ack,
           out_checksum,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tccf_front.sv =====
// Front part: accepts items, runs the connection state machine, queues headers.
// Depends on tccf_pkg and tccf_in_if.
`default_nettype none

module tccf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  tccf_in_if.sink             in_ch,
  input  wire tccf_pkg::cfg_t cfg,
  input  wire logic           q_full,
  output tccf_pkg::hdr_t      hdr,
  output logic                push
);

  typedef enum logic [1:0] {
    ST_CLOSED      = 2'd0,
    ST_SYN_SENT    = 2'd1,
    ST_ESTABLISHED = 2'd2,
    ST_FIN_SENT    = 2'd3
  } conn_state_t;

  conn_state_t st, st_next, st_mid;
  logic [7:0]  idle_count, idle_count_next, idle_inc;
  logic [15:0] peer_src_port, peer_src_port_next;
  logic [15:0] peer_dst_port, peer_dst_port_next;
  logic [31:0] peer_src_addr, peer_src_addr_next;
  logic [31:0] peer_dst_addr, peer_dst_addr_next;
  logic [31:0] send_seq, send_seq_next;
  logic [31:0] recv_ack, recv_ack_next;
  logic [31:0] pos;
  logic [7:0]  emit_flags;
  logic        emit;
  logic        accept;
  logic        synack;
  logic        match;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign match = (peer_src_port == in_ch.seg_src_port) &&
                 (peer_dst_port == in_ch.seg_dst_port) &&
                 (peer_src_addr == in_ch.seg_src_addr) &&
                 (peer_dst_addr == in_ch.seg_dst_addr);

  // Work out next connection state and whether a header goes out
  always_comb begin
    st_next            = st;
    st_mid             = st;
    idle_inc           = '0;
    idle_count_next    = idle_count;
    peer_src_port_next = peer_src_port;
    peer_dst_port_next = peer_dst_port;
    peer_src_addr_next = peer_src_addr;
    peer_dst_addr_next = peer_dst_addr;
    send_seq_next      = send_seq;
    recv_ack_next      = recv_ack;
    pos                = in_ch.seg_ack - (cfg.initial_sequence + 32'd1);
    emit               = 1'b0;
    emit_flags         = tccf_pkg::FL_NONE;
    synack             = 1'b0;
    if (in_ch.command == tccf_pkg::CMD_OPEN) begin
      // Restart the handshake
      peer_src_port_next = cfg.open_src_port;
      peer_dst_port_next = cfg.open_dst_port;
      send_seq_next      = cfg.initial_sequence;
      st_next            = ST_SYN_SENT;
      emit               = 1'b1;
      emit_flags         = tccf_pkg::FL_SYN;
    end else begin
      // Advance idle counter; force close at the limit
      if (st != ST_CLOSED) begin
        idle_inc = idle_count + 8'd1;
      end
      idle_count_next = idle_inc;
      if (idle_inc == cfg.timeout_limit) begin
        idle_count_next = '0;
        st_mid          = ST_CLOSED;
      end
      st_next = st_mid;
      synack  = ((in_ch.seg_flags & tccf_pkg::FL_SYN) != 8'd0) &&
                ((in_ch.seg_flags & tccf_pkg::FL_ACK) != 8'd0) &&
                (st_mid == ST_SYN_SENT);
      if (synack) begin
        // Capture the peer and acknowledge
        peer_src_port_next = in_ch.seg_src_port;
        peer_dst_port_next = in_ch.seg_dst_port;
        peer_src_addr_next = in_ch.seg_src_addr;
        peer_dst_addr_next = in_ch.seg_dst_addr;
        recv_ack_next      = in_ch.seg_seq + 32'd1;
        send_seq_next      = in_ch.seg_seq + 32'd2;
        st_next            = ST_ESTABLISHED;
        emit               = 1'b1;
        emit_flags         = tccf_pkg::FL_ACK;
      end else if (match) begin
        if ((in_ch.seg_flags & tccf_pkg::FL_RST) != 8'd0) begin
          st_next = ST_CLOSED;
        end else if (st_mid == ST_FIN_SENT) begin
          // Answer after FIN with reset
          send_seq_next = in_ch.seg_ack;
          st_next       = ST_CLOSED;
          emit          = 1'b1;
          emit_flags    = tccf_pkg::FL_RST;
        end else if (st_mid == ST_ESTABLISHED) begin
          recv_ack_next = in_ch.seg_seq +
                          ({21'd0, in_ch.seg_length} - tccf_pkg::HDR_BYTES);
          send_seq_next = in_ch.seg_ack;
          // Pure initial ACK from the peer: stay, send nothing
          if (!(pos == 32'd0 && in_ch.seg_length == tccf_pkg::HDR_LEN)) begin
            st_next = ST_FIN_SENT;
            emit    = 1'b1;
            if (pos == {16'd0, cfg.data_total}) begin
              emit_flags = tccf_pkg::FL_FIN | tccf_pkg::FL_ACK;
            end else begin
              emit_flags = tccf_pkg::FL_ACK;
            end
          end
        end
      end
    end
  end

  // Header carries the values after the update
  assign hdr.flags    = emit_flags;
  assign hdr.src_port = peer_dst_port_next;
  assign hdr.dst_port = peer_src_port_next;
  assign hdr.seq      = send_seq_next;
  assign hdr.ack      = recv_ack_next;
  assign hdr.src_addr = peer_src_addr_next;
  assign hdr.dst_addr = peer_dst_addr_next;
  assign hdr.window   = cfg.advertised_window;
  assign push         = accept && emit;

  // Hold connection state; update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_CLOSED;
      idle_count    <= '0;
      peer_src_port <= '0;
      peer_dst_port <= '0;
      peer_src_addr <= tccf_pkg::RST_SRC_ADDR;
      peer_dst_addr <= tccf_pkg::RST_DST_ADDR;
      send_seq      <= tccf_pkg::RST_INIT_SEQ;
      recv_ack      <= '0;
    end else if (accept) begin
      st            <= st_next;
      idle_count    <= idle_count_next;
      peer_src_port <= peer_src_port_next;
      peer_dst_port <= peer_dst_port_next;
      peer_src_addr <= peer_src_addr_next;
      peer_dst_addr <= peer_dst_addr_next;
      send_seq      <= send_seq_next;
      recv_ack      <= recv_ack_next;
    end
  end

  a_open_enters_syn_sent: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.command == tccf_pkg::CMD_OPEN |=> st == ST_SYN_SENT)
    else $error("open request did not enter SYN sent");

  a_closed_idle_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.command == tccf_pkg::CMD_SEGMENT && st == ST_CLOSED
    |=> idle_count == 8'd0)
    else $error("idle counter not cleared by segment while closed");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("header queued while queue full");

endmodule

`default_nettype wire

// ===== rtl/tccf_queue.sv =====
// Short header queue between the front and back parts.
// Depends on tccf_pkg.
`default_nettype none

module tccf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tccf_pkg::hdr_t push_hdr,
  output logic                full,
  input  wire logic           pop,
  output tccf_pkg::hdr_t      pop_hdr,
  output logic                not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tccf_pkg::hdr_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_hdr   = mem[rd_ptr];

  // Store pushed header
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_hdr;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== rtl/tccf_back.sv =====
// Back part: sums the header checksum and holds the result for the receiver.
// Depends on tccf_pkg and tccf_out_if.
`default_nettype none

module tccf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire tccf_pkg::hdr_t q_hdr,
  output logic                pop,
  tccf_out_if.source          out_ch
);

  logic           sum_valid;
  tccf_pkg::hdr_t sum_hdr;
  logic [19:0]    sum;
  logic [19:0]    sum_in;
  logic [16:0]    fold1;
  logic [16:0]    fold2;
  logic           out_adv;

  // Ones'-complement sum of pseudo-header and header words
  assign sum_in = 20'(q_hdr.src_addr[31:16]) + 20'(q_hdr.src_addr[15:0]) +
                  20'(q_hdr.dst_addr[31:16]) + 20'(q_hdr.dst_addr[15:0]) +
                  20'(tccf_pkg::PSEUDO_WORD) +
                  20'(q_hdr.src_port) + 20'(q_hdr.dst_port) +
                  20'(q_hdr.seq[31:16]) + 20'(q_hdr.seq[15:0]) +
                  20'(q_hdr.ack[31:16]) + 20'(q_hdr.ack[15:0]) +
                  20'(tccf_pkg::OFFSET_WORD | {8'd0, q_hdr.flags}) +
                  20'(q_hdr.window);

  // Fold carries twice
  assign fold1 = 17'(sum[19:16]) + 17'(sum[15:0]);
  assign fold2 = 17'(fold1[16]) + 17'(fold1[15:0]);

  assign out_adv = sum_valid && (!out_ch.valid || out_ch.ready);
  assign pop     = q_valid && (!sum_valid || out_adv);

  // Sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (pop) begin
      sum_valid <= 1'b1;
    end else if (out_adv) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sum_hdr <= q_hdr;
      sum     <= sum_in;
    end
  end

  // Output register; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_adv) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_ch.out_flags    <= sum_hdr.flags;
      out_ch.out_src_port <= sum_hdr.src_port;
      out_ch.out_dst_port <= sum_hdr.dst_port;
      out_ch.out_seq      <= sum_hdr.seq;
      out_ch.out_ack      <= sum_hdr.ack;
      out_ch.out_checksum <= ~fold2[15:0];
    end
  end

  a_pop_when_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop without queued header");

  a_sum_moves_out: assert property (@(posedge clk) disable iff (rst)
    out_adv |=> out_ch.valid)
    else $error("summed header did not reach output");

  a_no_sum_overwrite: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !out_adv |-> !pop)
    else $error("sum stage overwritten while held");

endmodule

`default_nettype wire

// ===== rtl/tcp_client_connection_fsm_top.sv =====
// TCP client connection block, top level: configuration registers and wiring.
// Depends on tccf_pkg, tccf_in_if, tccf_out_if, tccf_front, tccf_queue, tccf_back.
//
// Usage:
//  in_ch carries open requests (command 0) and parsed received segment headers
//  (command 1); out_ch carries the 20-byte headers to send, zero or one per
//  input item, with the checksum over pseudo-header and header filled in.
//  Both channels move an item when valid and ready are high at a clock edge.
//  The APB port writes the six settings at byte address 4*index; pready is
//  always high and reads return the stored value. Write only while idle.
//  Throughput: one item per cycle while the queue is not full. The
//  connection state updates in the cycle an item is accepted, so a following
//  item sees it at once. A header is written to the queue at the accepting
//  edge, then passes the checksum register and the output register to out_ch.
//  When the receiver stalls, headers pile up in the sum stage, the queue of
//  QUEUE_DEPTH entries and the output register; in_ch.ready drops only when
//  the queue is full. Items that send nothing still wait for that room.
//  Reset (rst, synchronous) closes the connection, loads the default
//  settings and addresses and empties the queue and output stages.
`default_nettype none

module tcp_client_connection_fsm_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tccf_in_if.sink                            in_ch,
  tccf_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tccf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  tccf_pkg::cfg_t cfg;
  tccf_pkg::hdr_t push_hdr;
  tccf_pkg::hdr_t pop_hdr;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[tccf_pkg::PADDR_W-1:2];

  // Write settings
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_src_port     <= tccf_pkg::RST_OPEN_SRC_PORT;
      cfg.open_dst_port     <= tccf_pkg::RST_OPEN_DST_PORT;
      cfg.initial_sequence  <= tccf_pkg::RST_INIT_SEQ;
      cfg.timeout_limit     <= tccf_pkg::RST_TIMEOUT;
      cfg.advertised_window <= tccf_pkg::RST_WINDOW;
      cfg.data_total        <= tccf_pkg::RST_DATA_TOTAL;
    end else if (cfg_wr) begin
      case (reg_idx)
        tccf_pkg::REG_OPEN_SRC_PORT: cfg.open_src_port     <= pwdata[15:0];
        tccf_pkg::REG_OPEN_DST_PORT: cfg.open_dst_port     <= pwdata[15:0];
        tccf_pkg::REG_INIT_SEQ:      cfg.initial_sequence  <= pwdata;
        tccf_pkg::REG_TIMEOUT:       cfg.timeout_limit     <= pwdata[7:0];
        tccf_pkg::REG_WINDOW:        cfg.advertised_window <= pwdata[15:0];
        tccf_pkg::REG_DATA_TOTAL:    cfg.data_total        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back settings
  always_comb begin
    case (reg_idx)
      tccf_pkg::REG_OPEN_SRC_PORT: prdata = {16'd0, cfg.open_src_port};
      tccf_pkg::REG_OPEN_DST_PORT: prdata = {16'd0, cfg.open_dst_port};
      tccf_pkg::REG_INIT_SEQ:      prdata = cfg.initial_sequence;
      tccf_pkg::REG_TIMEOUT:       prdata = {24'd0, cfg.timeout_limit};
      tccf_pkg::REG_WINDOW:        prdata = {16'd0, cfg.advertised_window};
      tccf_pkg::REG_DATA_TOTAL:    prdata = {16'd0, cfg.data_total};
      default:                     prdata = '0;
    endcase
  end

  tccf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .hdr    (push_hdr),
    .push   (push)
  );

  tccf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_hdr  (push_hdr),
    .full      (q_full),
    .pop       (pop),
    .pop_hdr   (pop_hdr),
    .not_empty (q_valid)
  );

  tccf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_hdr   (pop_hdr),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the TCP client connection block: random and directed
// items, a connection tracker that predicts each sent header, APB setup writes.
// Depends on tccf_pkg, tccf_in_if, tccf_out_if and tcp_client_connection_fsm_top.

module testbench;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [7:0] FL_PSH = 8'h08;

  typedef enum logic [1:0] {
    LINK_CLOSED, LINK_SYN_SENT, LINK_ESTABLISHED, LINK_FIN_SENT
  } link_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  flags;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [31:0] sseq;
    logic [31:0] sack;
    logic [10:0] len;
  } seg_item_t;

  typedef struct packed {
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] saddr;
    logic [31:0] daddr;
  } tuple_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] csum;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Stimulus-side registers, all but the APB read-back pair known from time zero
  logic                         drv_valid = 1'b0;
  seg_item_t                    drv_item  = '0;
  logic                         rcv_ready = 1'b0;
  logic                         apb_sel   = 1'b0;
  logic                         apb_en    = 1'b0;
  logic                         apb_write = 1'b0;
  logic [tccf_pkg::PADDR_W-1:0] apb_addr  = '0;
  logic [31:0]                  apb_wdata = '0;
  logic [31:0]                  apb_rdata;
  logic                         apb_ready;

  seg_item_t pending_items[$];
  reply_t    expected_replies[$];
  int        items_queued = 0;
  int        items_taken  = 0;
  int        mismatches   = 0;
  int        stall_cycles = 0;
  logic      seg_taken    = 1'b0;
  int        burst_left   = 8;
  int        gap_left     = 0;
  int        rcv_run      = 0;
  int        rcv_mode     = 0;

  // Tracked connection state and settings
  tccf_pkg::cfg_t cfg = '{open_src_port: tccf_pkg::RST_OPEN_SRC_PORT,
                          open_dst_port: tccf_pkg::RST_OPEN_DST_PORT,
                          initial_sequence: tccf_pkg::RST_INIT_SEQ,
                          timeout_limit: tccf_pkg::RST_TIMEOUT,
                          advertised_window: tccf_pkg::RST_WINDOW,
                          data_total: tccf_pkg::RST_DATA_TOTAL};
  link_t       link_st    = LINK_CLOSED;
  logic [7:0]  idle_cnt   = '0;
  logic [15:0] peer_sport = '0;
  logic [15:0] peer_dport = '0;
  logic [31:0] peer_saddr = tccf_pkg::RST_SRC_ADDR;
  logic [31:0] peer_daddr = tccf_pkg::RST_DST_ADDR;
  logic [31:0] tx_seq     = tccf_pkg::RST_INIT_SEQ;
  logic [31:0] rx_ack     = '0;

  tccf_in_if  seg_ch ();
  tccf_out_if hdr_ch ();

  assign seg_ch.valid        = drv_valid;
  assign seg_ch.command      = drv_item.cmd;
  assign seg_ch.seg_flags    = drv_item.flags;
  assign seg_ch.seg_src_port = drv_item.sport;
  assign seg_ch.seg_dst_port = drv_item.dport;
  assign seg_ch.seg_src_addr = drv_item.saddr;
  assign seg_ch.seg_dst_addr = drv_item.daddr;
  assign seg_ch.seg_seq      = drv_item.sseq;
  assign seg_ch.seg_ack      = drv_item.sack;
  assign seg_ch.seg_length   = drv_item.len;
  assign hdr_ch.ready        = rcv_ready;

  tcp_client_connection_fsm_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (seg_ch),
    .out_ch  (hdr_ch),
    .psel    (apb_sel),
    .penable (apb_en),
    .pwrite  (apb_write),
    .paddr   (apb_addr),
    .pwdata  (apb_wdata),
    .prdata  (apb_rdata),
    .pready  (apb_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ones' complement sum over pseudo-header and reply header
  function automatic logic [15:0] reply_checksum(input logic [7:0] flags);
    logic [31:0] acc;
    acc = 32'(peer_saddr[31:16]) + 32'(peer_saddr[15:0])
        + 32'(peer_daddr[31:16]) + 32'(peer_daddr[15:0])
        + 32'(tccf_pkg::PSEUDO_WORD) + 32'(peer_dport) + 32'(peer_sport)
        + 32'(tx_seq[31:16]) + 32'(tx_seq[15:0])
        + 32'(rx_ack[31:16]) + 32'(rx_ack[15:0])
        + 32'(tccf_pkg::OFFSET_WORD | {8'd0, flags}) + 32'(cfg.advertised_window);
    acc = 32'(acc[31:16]) + 32'(acc[15:0]);
    acc = 32'(acc[31:16]) + 32'(acc[15:0]);
    return ~acc[15:0];
  endfunction

  task automatic queue_reply(input logic [7:0] flags);
    expected_replies.push_back('{flags: flags, sport: peer_dport, dport: peer_sport,
                                 seq: tx_seq, ack: rx_ack, csum: reply_checksum(flags)});
  endtask

  // Advance the tracked connection by one accepted item
  task automatic connection_step(input seg_item_t it);
    logic [31:0] pos;
    if (it.cmd == tccf_pkg::CMD_OPEN) begin
      peer_sport = cfg.open_src_port;
      peer_dport = cfg.open_dst_port;
      tx_seq     = cfg.initial_sequence;
      link_st    = LINK_SYN_SENT;
      queue_reply(tccf_pkg::FL_SYN);
      return;
    end
    // idle timeout counts every segment while open
    if (link_st != LINK_CLOSED) idle_cnt = idle_cnt + 8'd1;
    else idle_cnt = '0;
    if (idle_cnt == cfg.timeout_limit) begin
      idle_cnt = '0;
      link_st  = LINK_CLOSED;
    end
    // capture the SYN-ACK
    if ((it.flags & tccf_pkg::FL_SYN) != tccf_pkg::FL_NONE &&
        (it.flags & tccf_pkg::FL_ACK) != tccf_pkg::FL_NONE &&
        link_st == LINK_SYN_SENT) begin
      peer_sport = it.sport;
      peer_dport = it.dport;
      peer_saddr = it.saddr;
      peer_daddr = it.daddr;
      rx_ack     = it.sseq + 32'd1;
      tx_seq     = rx_ack + 32'd1;
      link_st    = LINK_ESTABLISHED;
      queue_reply(tccf_pkg::FL_ACK);
      return;
    end
    // drop foreign segments
    if (peer_sport != it.sport || peer_dport != it.dport ||
        peer_daddr != it.daddr || peer_saddr != it.saddr) return;
    if ((it.flags & tccf_pkg::FL_RST) != tccf_pkg::FL_NONE) begin
      link_st = LINK_CLOSED;
      return;
    end
    if (link_st == LINK_FIN_SENT) begin
      tx_seq  = it.sack;
      link_st = LINK_CLOSED;
      queue_reply(tccf_pkg::FL_RST);
      return;
    end
    if (link_st == LINK_ESTABLISHED) begin
      rx_ack = it.sseq + (32'(it.len) - tccf_pkg::HDR_BYTES);
      tx_seq = it.sack;
      pos    = tx_seq - (cfg.initial_sequence + 32'd1);
      // the pure initial ACK sends nothing
      if (pos == 32'd0 && it.len == tccf_pkg::HDR_LEN) return;
      link_st = LINK_FIN_SENT;
      queue_reply((pos == {16'd0, cfg.data_total}) ?
                  (tccf_pkg::FL_FIN | tccf_pkg::FL_ACK) : tccf_pkg::FL_ACK);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t header mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("unexpected header", 32'(hdr_ch.out_flags), '0);
      return;
    end
    want = expected_replies.pop_front();
    if (hdr_ch.out_flags !== want.flags)
      report_mismatch("flags", 32'(hdr_ch.out_flags), 32'(want.flags));
    if (hdr_ch.out_src_port !== want.sport)
      report_mismatch("src_port", 32'(hdr_ch.out_src_port), 32'(want.sport));
    if (hdr_ch.out_dst_port !== want.dport)
      report_mismatch("dst_port", 32'(hdr_ch.out_dst_port), 32'(want.dport));
    if (hdr_ch.out_seq !== want.seq)
      report_mismatch("seq", hdr_ch.out_seq, want.seq);
    if (hdr_ch.out_ack !== want.ack)
      report_mismatch("ack", hdr_ch.out_ack, want.ack);
    if (hdr_ch.out_checksum !== want.csum)
      report_mismatch("checksum", 32'(hdr_ch.out_checksum), 32'(want.csum));
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    seg_item_t it;
    if (rst) begin
      seg_taken    <= 1'b0;
      stall_cycles = 0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) check_reply();
      seg_taken <= seg_ch.valid && seg_ch.ready;
      if (seg_ch.valid && seg_ch.ready) begin
        it.cmd   = seg_ch.command;
        it.flags = seg_ch.seg_flags;
        it.sport = seg_ch.seg_src_port;
        it.dport = seg_ch.seg_dst_port;
        it.saddr = seg_ch.seg_src_addr;
        it.daddr = seg_ch.seg_dst_addr;
        it.sseq  = seg_ch.seg_seq;
        it.sack  = seg_ch.seg_ack;
        it.len   = seg_ch.seg_length;
        connection_step(it);
        items_taken++;
      end
      if ((seg_ch.valid && seg_ch.ready) || (hdr_ch.valid && hdr_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Sender: bursts of items with random gaps, hold the item until taken
  always @(negedge clk) begin
    logic      nv;
    seg_item_t ni;
    nv = drv_valid;
    ni = drv_item;
    if (rst) begin
      nv = 1'b0;
    end else if (!drv_valid || seg_taken) begin
      nv = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_items.size() != 0) begin
        ni = pending_items.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    drv_valid <= nv;
    drv_item  <= ni;
  end

  // Receiver: runs of steady ready, steady stall, or coin flips
  always @(negedge clk) begin
    if (rcv_run == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_run  = $urandom_range(1, 24);
    end else begin
      rcv_run--;
    end
    case (rcv_mode)
      2: rcv_ready <= 1'b0;
      3: rcv_ready <= 1'($urandom_range(0, 1));
      default: rcv_ready <= 1'b1;
    endcase
  end

  task automatic write_setting(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    apb_sel   = 1'b1;
    apb_en    = 1'b0;
    apb_write = 1'b1;
    apb_addr  = tccf_pkg::PADDR_W'({idx, 2'b00});
    apb_wdata = value;
    @(negedge clk);
    apb_en = 1'b1;
    do @(posedge clk); while (apb_ready !== 1'b1);
    @(negedge clk);
    apb_sel = 1'b0;
    apb_en  = 1'b0;
    case (idx)
      tccf_pkg::REG_OPEN_SRC_PORT: cfg.open_src_port     = value[15:0];
      tccf_pkg::REG_OPEN_DST_PORT: cfg.open_dst_port     = value[15:0];
      tccf_pkg::REG_INIT_SEQ:      cfg.initial_sequence  = value;
      tccf_pkg::REG_TIMEOUT:       cfg.timeout_limit     = value[7:0];
      tccf_pkg::REG_WINDOW:        cfg.advertised_window = value[15:0];
      tccf_pkg::REG_DATA_TOTAL:    cfg.data_total        = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input tccf_pkg::cfg_t c);
    write_setting(tccf_pkg::REG_OPEN_SRC_PORT, 32'(c.open_src_port));
    write_setting(tccf_pkg::REG_OPEN_DST_PORT, 32'(c.open_dst_port));
    write_setting(tccf_pkg::REG_INIT_SEQ, c.initial_sequence);
    write_setting(tccf_pkg::REG_TIMEOUT, 32'(c.timeout_limit));
    write_setting(tccf_pkg::REG_WINDOW, 32'(c.advertised_window));
    write_setting(tccf_pkg::REG_DATA_TOTAL, 32'(c.data_total));
  endtask

  // Wait until every item is in and every header is out, then let the pipe empty
  task automatic drain_and_settle();
    do @(negedge clk);
    while (items_taken != items_queued || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_item(input seg_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_open();
    seg_item_t it;
    it.cmd   = tccf_pkg::CMD_OPEN;
    it.flags = 8'($urandom);
    it.sport = 16'($urandom);
    it.dport = 16'($urandom);
    it.saddr = $urandom;
    it.daddr = $urandom;
    it.sseq  = $urandom;
    it.sack  = $urandom;
    it.len   = 11'($urandom_range(20, 1480));
    push_item(it);
  endtask

  task automatic push_segment(input logic [7:0] flags, input tuple_t t,
                              input logic [31:0] sseq, input logic [31:0] sack,
                              input logic [10:0] len);
    push_item('{cmd: tccf_pkg::CMD_SEGMENT, flags: flags, sport: t.sport,
                dport: t.dport, saddr: t.saddr, daddr: t.daddr, sseq: sseq,
                sack: sack, len: len});
  endtask

  function automatic logic [10:0] rand_len();
    if ($urandom_range(0, 7) == 0) return tccf_pkg::HDR_LEN;
    return 11'($urandom_range(20, 1480));
  endfunction

  function automatic tuple_t rand_tuple();
    return '{sport: 16'($urandom), dport: 16'($urandom), saddr: $urandom, daddr: $urandom};
  endfunction

  // Flip one bit of one field so the segment is foreign
  function automatic tuple_t skew_tuple(input tuple_t t);
    case ($urandom_range(0, 3))
      0: t.sport ^= 16'(1) << $urandom_range(0, 15);
      1: t.dport ^= 16'(1) << $urandom_range(0, 15);
      2: t.saddr ^= 32'(1) << $urandom_range(0, 31);
      default: t.daddr ^= 32'(1) << $urandom_range(0, 31);
    endcase
    return t;
  endfunction

  // One connection attempt: usually an open, a SYN-ACK, up to four segments, most on the same tuple
  task automatic add_session();
    tuple_t      t;
    logic [7:0]  fl;
    logic [31:0] final_pos;
    t = rand_tuple();
    final_pos = cfg.initial_sequence + 32'd1 + {16'd0, cfg.data_total};
    if ($urandom_range(0, 9) != 0) push_open();
    push_segment(8'($urandom) | tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, t, $urandom,
                 $urandom, rand_len());
    repeat ($urandom_range(0, 4)) begin
      fl = 8'($urandom) & ~tccf_pkg::FL_RST;
      case ($urandom_range(0, 7))
        0: push_segment(tccf_pkg::FL_ACK, t, $urandom, cfg.initial_sequence + 32'd1,
                        tccf_pkg::HDR_LEN);
        1: push_segment(fl, skew_tuple(t), $urandom, $urandom, rand_len());
        2: push_segment(8'($urandom) | tccf_pkg::FL_RST, t, $urandom, $urandom,
                        rand_len());
        3: push_segment(fl, t, $urandom, final_pos, rand_len());
        default: push_segment(fl, t, $urandom, $urandom, rand_len());
      endcase
    end
  endtask

  task automatic add_noise();
    tuple_t t;
    t = rand_tuple();
    case ($urandom_range(0, 2))
      0: push_open();
      1: push_segment(8'($urandom) | tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, t, $urandom,
                      $urandom, rand_len());
      default: push_segment(8'($urandom), t, $urandom, $urandom, rand_len());
    endcase
  endtask

  task automatic add_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_session();
    end
  endtask

  function automatic tccf_pkg::cfg_t rand_settings();
    tccf_pkg::cfg_t c;
    c.open_src_port     = 16'($urandom);
    c.open_dst_port     = 16'($urandom);
    c.initial_sequence  = $urandom;
    c.timeout_limit     = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(2, 12))
                                                      : 8'($urandom_range(1, 255));
    c.advertised_window = 16'($urandom);
    c.data_total        = 16'($urandom);
    return c;
  endfunction

  // Stop the run when nothing moves for too long
  initial begin
    do @(negedge clk); while (stall_cycles < STALL_LIMIT);
    $display("tcp_client_connection_fsm_top: mismatch");
    $finish;
  end

  initial begin
    tuple_t ones, zeros, opened;
    ones   = '{sport: 16'hFFFF, dport: 16'hFFFF, saddr: 32'hFFFFFFFF, daddr: 32'hFFFFFFFF};
    zeros  = '0;
    opened = '{sport: tccf_pkg::RST_OPEN_SRC_PORT, dport: tccf_pkg::RST_OPEN_DST_PORT,
               saddr: '0, daddr: '0};
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, every branch of the connection
    push_segment(8'hFF, ones, '0, '0, 11'd1480);           // segment while closed
    push_open();
    push_segment(8'hFF, ones, 32'hFFFFFFFF, '0, tccf_pkg::HDR_LEN);  // SYN-ACK, ack wraps
    push_segment(tccf_pkg::FL_ACK, ones, '0, tccf_pkg::RST_INIT_SEQ + 32'd1,
                 tccf_pkg::HDR_LEN);                       // pure initial ACK
    push_segment(tccf_pkg::FL_ACK, '{sport: '0, dport: 16'hFFFF, saddr: 32'hFFFFFFFF,
                                     daddr: 32'hFFFFFFFF}, '0, '0, 11'd40);  // foreign port
    push_segment(tccf_pkg::FL_ACK, ones, 32'd5,
                 tccf_pkg::RST_INIT_SEQ + 32'd1 + 32'(tccf_pkg::RST_DATA_TOTAL),
                 11'd19);                                  // short length, FIN|ACK
    push_segment(tccf_pkg::FL_NONE, ones, '0, 32'hFFFFFFFF, tccf_pkg::HDR_LEN);  // reply RST
    push_open();
    push_segment(tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, zeros, '0, '0, tccf_pkg::HDR_LEN);
    push_segment(tccf_pkg::FL_ACK | tccf_pkg::FL_FIN, zeros, '0, '0, 11'd0);  // zero length
    push_open();                                           // restart from FIN sent
    push_segment(tccf_pkg::FL_ACK, opened, $urandom, $urandom,
                 tccf_pkg::HDR_LEN);                       // SYN sent, no SYN-ACK
    push_segment(tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, ones, 32'd100, '0, tccf_pkg::HDR_LEN);
    push_open();                                           // restart while established
    push_segment(tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, zeros, 32'd7, '0, tccf_pkg::HDR_LEN);
    push_segment(tccf_pkg::FL_ACK | FL_PSH, zeros, $urandom, $urandom, 11'd1480);
    push_segment(tccf_pkg::FL_RST, zeros, '0, '0, tccf_pkg::HDR_LEN);   // RST in FIN sent
    push_open();
    push_segment(tccf_pkg::FL_RST, opened, '0, '0, tccf_pkg::HDR_LEN);  // RST in SYN sent
    push_segment(tccf_pkg::FL_NONE, opened, '0, '0, tccf_pkg::HDR_LEN); // matching, closed
    push_open();
    push_segment(tccf_pkg::FL_SYN | tccf_pkg::FL_ACK, ones, 32'h7FFFFFFF, '0,
                 tccf_pkg::HDR_LEN);
    push_segment(tccf_pkg::FL_ACK, ones, '0, 32'h12345678, tccf_pkg::HDR_LEN);
    push_segment(tccf_pkg::FL_FIN, ones, '0, '0, tccf_pkg::HDR_LEN);
    drain_and_settle();

    // Extremes of every setting
    load_settings('{open_src_port: 16'h0000, open_dst_port: 16'hFFFF,
                    initial_sequence: 32'hFFFFFFFF, timeout_limit: 8'd255,
                    advertised_window: 16'hFFFF, data_total: 16'h0000});
    add_random(200);
    drain_and_settle();

    load_settings('{open_src_port: 16'hFFFF, open_dst_port: 16'h0000,
                    initial_sequence: 32'h00000000, timeout_limit: 8'd1,
                    advertised_window: 16'h0000, data_total: 16'hFFFF});
    add_random(60);
    drain_and_settle();

    // Random settings; hold off mid-phase until all headers are out
    load_settings(rand_settings());
    add_random(125);
    drain_and_settle();
    add_random(125);
    drain_and_settle();

    load_settings(rand_settings());
    write_setting(tccf_pkg::REG_TIMEOUT, 32'd30);
    add_random(216);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("tcp_client_connection_fsm_top: match");
    end else begin
      $display("tcp_client_connection_fsm_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tccf_pkg.sv
rtl/tccf_in_if.sv
rtl/tccf_out_if.sv
rtl/tccf_front.sv
rtl/tccf_queue.sv
rtl/tccf_back.sv
rtl/tcp_client_connection_fsm_top.sv
tb/sv/testbench.sv
